FILE: hdl/nibble_framebuffer_draw_engine_assert.svh
// Assertion macros shared by the draw engine modules.
`ifndef NIBBLE_FRAMEBUFFER_DRAW_ENGINE_ASSERT_SVH
`define NIBBLE_FRAMEBUFFER_DRAW_ENGINE_ASSERT_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define NFB_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("nfb: same-cycle check failed");

// Next-cycle implication, clocked on i_clk, off during reset.
`define NFB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("nfb: next-cycle check failed");

`endif

FILE: hdl/nfb_pkg.sv
// Shared types and constants of the nibble frame buffer draw engine.
package nfb_pkg;

    typedef enum logic [2:0] {
        OP_SET_PIXEL  = 3'd0,
        OP_VLINE      = 3'd1,
        OP_HLINE      = 3'd2,
        OP_FILL_RECT  = 3'd3,
        OP_READ_PIXEL = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_FILL,
        ST_READ,
        ST_RESULT
    } t_state;

    localparam logic [7:0] HI_NIBBLE_MASK = 8'hF0;
    localparam logic [7:0] LO_NIBBLE_MASK = 8'h0F;

    typedef struct packed {
        logic clr;
        logic load;
        logic setup;
        logic fill;
        logic rd;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic draw;
        logic is_read;
        logic rd_on;
        logic row_end;
        logic last_row;
        logic out_free;
    } t_stat;

endpackage

FILE: hdl/nfb_intf.sv
// Valid/ready channel interfaces for draw commands and read results.
interface nfb_in_if;
    logic              valid;
    logic              ready;
    logic [2:0]        operation;
    logic signed [7:0] x_pos;
    logic signed [7:0] y_pos;
    logic [7:0]        width_px;
    logic [7:0]        height_px;
    logic [3:0]        color;

    modport source (
        output valid, operation, x_pos, y_pos, width_px, height_px, color,
        input  ready
    );
    modport sink (
        input  valid, operation, x_pos, y_pos, width_px, height_px, color,
        output ready
    );
endinterface

interface nfb_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] pixel_value;
    logic       on_screen;

    modport source (
        output valid, pixel_value, on_screen,
        input  ready
    );
    modport sink (
        input  valid, pixel_value, on_screen,
        output ready
    );
endinterface

FILE: hdl/nfb_ctrl.sv
// Controller state machine of the draw engine.
module nfb_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  nfb_pkg::t_stat i_stat,
    output nfb_pkg::t_cmd  o_cmd
);

    nfb_pkg::t_state r_state;
    nfb_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nfb_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            nfb_pkg::ST_CLEAR: begin
                if (i_stat.clr_last) n_state = nfb_pkg::ST_IDLE;
            end
            nfb_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = nfb_pkg::ST_SETUP;
            end
            nfb_pkg::ST_SETUP: begin
                if (i_stat.draw) begin
                    n_state = nfb_pkg::ST_FILL;
                end else if (i_stat.is_read && i_stat.rd_on) begin
                    n_state = nfb_pkg::ST_READ;
                end else if (i_stat.is_read) begin
                    n_state = nfb_pkg::ST_RESULT;
                end else begin
                    n_state = nfb_pkg::ST_IDLE;
                end
            end
            nfb_pkg::ST_FILL: begin
                if (i_stat.row_end && i_stat.last_row) n_state = nfb_pkg::ST_IDLE;
            end
            nfb_pkg::ST_READ: begin
                n_state = nfb_pkg::ST_RESULT;
            end
            nfb_pkg::ST_RESULT: begin
                if (i_stat.out_free) n_state = nfb_pkg::ST_IDLE;
            end
            default: begin
                n_state = nfb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            nfb_pkg::ST_CLEAR: begin
                o_cmd.clr = 1'b1;
            end
            nfb_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            nfb_pkg::ST_SETUP: begin
                o_cmd.setup = 1'b1;
            end
            nfb_pkg::ST_FILL: begin
                o_cmd.fill = 1'b1;
            end
            nfb_pkg::ST_READ: begin
                o_cmd.rd = 1'b1;
            end
            nfb_pkg::ST_RESULT: begin
                o_cmd.out_load = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

`include "nibble_framebuffer_draw_engine_assert.svh"

    `NFB_ASSERT_NEXT(a_load_to_setup, o_cmd.load, r_state == nfb_pkg::ST_SETUP)
    `NFB_ASSERT_NEXT(a_read_to_result, r_state == nfb_pkg::ST_READ, r_state == nfb_pkg::ST_RESULT)
    `NFB_ASSERT_IMPL(a_result_slot_free, o_cmd.out_load, i_stat.out_free)

endmodule

FILE: hdl/nfb_datapath.sv
// Clipping, address walk, read-modify-write frame store and result register.
module nfb_datapath #(
    parameter int SCREEN_WIDTH  = 110,
    parameter int SCREEN_HEIGHT = 88
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  nfb_pkg::t_cmd     i_cmd,
    input  logic [2:0]        i_operation,
    input  logic signed [7:0] i_x_pos,
    input  logic signed [7:0] i_y_pos,
    input  logic [7:0]        i_width_px,
    input  logic [7:0]        i_height_px,
    input  logic [3:0]        i_color,
    input  logic              i_out_ready,
    output nfb_pkg::t_stat    o_stat,
    output logic              o_out_valid,
    output logic [3:0]        o_pixel_value,
    output logic              o_on_screen
);

    localparam int ROW_BYTES   = (SCREEN_WIDTH + 1) / 2;
    localparam int STORE_BYTES = ROW_BYTES * SCREEN_HEIGHT;
    localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int BW = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
    localparam int XW = $clog2(SCREEN_WIDTH + 1);
    localparam int YW = $clog2(SCREEN_HEIGHT + 1);
    localparam logic signed [9:0] W_S = 10'(SCREEN_WIDTH);
    localparam logic signed [9:0] H_S = 10'(SCREEN_HEIGHT);

    logic [7:0] mem [STORE_BYTES];

    // input clipping
    nfb_pkg::t_op      op;
    logic signed [9:0] xs, ys, xe, ye, x_end, y_end, x0c, x1c, y0c, y1c;
    logic              on_scr, origin_ok, is_draw_op, draw;

    always_comb begin
        op        = nfb_pkg::t_op'(i_operation);
        xs        = {{2{i_x_pos[7]}}, i_x_pos};
        ys        = {{2{i_y_pos[7]}}, i_y_pos};
        xe        = xs + {2'b00, i_width_px};
        ye        = ys + {2'b00, i_height_px};
        x_end     = (op == nfb_pkg::OP_HLINE || op == nfb_pkg::OP_FILL_RECT) ?
                    xe : xs + 10'sd1;
        y_end     = (op == nfb_pkg::OP_VLINE || op == nfb_pkg::OP_FILL_RECT) ?
                    ye : ys + 10'sd1;
        x0c       = (xs < 10'sd0) ? 10'sd0 : xs;
        y0c       = (ys < 10'sd0) ? 10'sd0 : ys;
        x1c       = (x_end > W_S) ? W_S : x_end;
        y1c       = (y_end > H_S) ? H_S : y_end;
        on_scr    = xs >= 10'sd0 && xs < W_S && ys >= 10'sd0 && ys < H_S;
        origin_ok = (op == nfb_pkg::OP_FILL_RECT) ? (xs < W_S && ys < H_S) : on_scr;
        is_draw_op = op == nfb_pkg::OP_SET_PIXEL || op == nfb_pkg::OP_VLINE ||
                     op == nfb_pkg::OP_HLINE || op == nfb_pkg::OP_FILL_RECT;
        draw      = is_draw_op && origin_ok && x1c > x0c && y1c > y0c;
    end

    logic [XW-1:0] r_x0, r_x1;
    logic [YW-1:0] r_y0, r_y1, r_row;
    logic [3:0]    r_color;
    logic          r_odd, r_draw, r_is_read, r_rd_on;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x0      <= XW'(x0c);
            r_x1      <= XW'(x1c);
            r_y0      <= YW'(y0c);
            r_y1      <= YW'(y1c);
            r_color   <= i_color;
            r_odd     <= xs[0];
            r_draw    <= draw;
            r_is_read <= op == nfb_pkg::OP_READ_PIXEL;
            r_rd_on   <= on_scr;
        end
    end

    // byte walk
    logic [AW+YW-1:0] base_prod;
    logic [BW-1:0]    bx_first, bx_last, r_bx;
    logic [AW-1:0]    r_base, rd_addr;
    logic [XW:0]      col_even, col_odd;
    logic             row_end, last_row, m_hi, m_lo;

    always_comb begin
        base_prod = (AW+YW)'(r_y0) * (AW+YW)'(ROW_BYTES);
        bx_first  = BW'(r_x0 >> 1);
        bx_last   = BW'(XW'(r_x1 - XW'(1)) >> 1);
        rd_addr   = r_base + AW'(r_bx);
        col_even  = (XW+1)'({r_bx, 1'b0});
        col_odd   = (XW+1)'({r_bx, 1'b1});
        m_hi      = col_even >= (XW+1)'(r_x0);
        m_lo      = col_odd < (XW+1)'(r_x1);
        row_end   = r_bx == bx_last;
        last_row  = r_row == YW'(r_y1 - YW'(1));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_base <= base_prod[AW-1:0];
            r_bx   <= bx_first;
            r_row  <= r_y0;
        end else if (i_cmd.fill) begin
            if (row_end) begin
                r_bx   <= bx_first;
                r_row  <= r_row + YW'(1);
                r_base <= r_base + AW'(ROW_BYTES);
            end else begin
                r_bx <= r_bx + BW'(1);
            end
        end
    end

    // frame store: read one cycle, merge and write the next
    logic          r_wr_vld;
    logic [AW-1:0] r_wr_addr, r_clr_addr, wr_addr;
    logic [1:0]    r_wr_mask;
    logic [7:0]    r_rdata, keep_mask, wr_data;
    logic          wr_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_vld   <= 1'b0;
            r_clr_addr <= '0;
        end else begin
            r_wr_vld <= i_cmd.fill;
            if (i_cmd.clr) r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fill) begin
            r_wr_addr <= rd_addr;
            r_wr_mask <= {m_hi, m_lo};
        end
    end

    always_comb begin
        keep_mask = (r_wr_mask[1] ? 8'h00 : nfb_pkg::HI_NIBBLE_MASK) |
                    (r_wr_mask[0] ? 8'h00 : nfb_pkg::LO_NIBBLE_MASK);
        wr_en     = i_cmd.clr || r_wr_vld;
        wr_addr   = i_cmd.clr ? r_clr_addr : r_wr_addr;
        wr_data   = i_cmd.clr ? 8'h00 :
                    ((r_rdata & keep_mask) | ({r_color, r_color} & ~keep_mask));
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (i_cmd.fill || i_cmd.rd) r_rdata <= mem[rd_addr];
    end

    // result register
    logic       r_out_vld, r_on;
    logic [3:0] r_pixel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_pixel <= !r_rd_on ? 4'h0 : (r_odd ? r_rdata[3:0] : r_rdata[7:4]);
            r_on    <= r_rd_on;
        end
    end

    always_comb begin
        o_stat.clr_last = r_clr_addr == AW'(STORE_BYTES - 1);
        o_stat.draw     = r_draw;
        o_stat.is_read  = r_is_read;
        o_stat.rd_on    = r_rd_on;
        o_stat.row_end  = row_end;
        o_stat.last_row = last_row;
        o_stat.out_free = !r_out_vld || i_out_ready;
        o_out_valid     = r_out_vld;
        o_pixel_value   = r_pixel;
        o_on_screen     = r_on;
    end

`include "nibble_framebuffer_draw_engine_assert.svh"

    `NFB_ASSERT_IMPL(a_no_clear_clash, r_wr_vld, !i_cmd.clr)
    `NFB_ASSERT_IMPL(a_fill_in_store, i_cmd.fill, (AW+1)'(rd_addr) < (AW+1)'(STORE_BYTES))
    `NFB_ASSERT_NEXT(a_write_follows_fill, i_cmd.fill, r_wr_vld && r_wr_addr == $past(rd_addr))

endmodule

FILE: hdl/nibble_framebuffer_draw_engine.sv
// Top level of the 4-bit-per-pixel frame buffer draw engine.
// Input channel i_cmd carries one draw or read word: operation (set pixel,
// vertical line, horizontal line, fill rectangle, read pixel), signed origin,
// width, height and color. All drawing is clipped to the screen.
// Output channel o_rsp carries pixel_value and on_screen, one word per read.
// Draw words produce no output word.
// Sequence: a draw word is accepted, then set up, then walks every touched
// store byte (bytes spanned by the clipped columns, times clipped rows). The
// byte walk does a read-modify-write through the single store, one byte a
// cycle. An on-screen read is accepted, set up, reads the store and loads
// the result register; off screen the store read is skipped. Empty draws and
// unused codes are only accepted and set up. A new word is taken only in idle.
// After reset the store is swept to zero, one byte a cycle, across all
// ROW_BYTES*SCREEN_HEIGHT bytes (4840 at the defaults) with i_cmd.ready low.
// The result sits in an output register; if o_rsp is stalled, a draw word
// still runs, but a following read holds until the register frees.
module nibble_framebuffer_draw_engine #(
    parameter int SCREEN_WIDTH  = 110,
    parameter int SCREEN_HEIGHT = 88
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    nfb_in_if.sink    i_cmd,
    nfb_out_if.source o_rsp
);

    nfb_pkg::t_cmd  cmd;
    nfb_pkg::t_stat stat;

    nfb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .o_in_ready (i_cmd.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    nfb_datapath #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_operation   (i_cmd.operation),
        .i_x_pos       (i_cmd.x_pos),
        .i_y_pos       (i_cmd.y_pos),
        .i_width_px    (i_cmd.width_px),
        .i_height_px   (i_cmd.height_px),
        .i_color       (i_cmd.color),
        .i_out_ready   (o_rsp.ready),
        .o_stat        (stat),
        .o_out_valid   (o_rsp.valid),
        .o_pixel_value (o_rsp.pixel_value),
        .o_on_screen   (o_rsp.on_screen)
    );

endmodule
